/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the shuffled generator.
// Depends on nothing; pulled in by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define SPMR_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spmr assertion failed");

// next-cycle implication
`define SPMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmr assertion failed");

`endif

/* rtl/spmr_pkg.sv */
// Constants and widths of the shuffled minimal-standard generator.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package spmr_pkg;

    localparam int TABLE_DEPTH    = 32;
    localparam int WARMUP_DISCARD = 8;

    localparam int VAL_W  = 31;
    localparam int FRAC_W = 24;
    localparam int MULT_W = 15;
    localparam int PROD_W = VAL_W + MULT_W;

    localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
    localparam logic [VAL_W:0]    LCG_MOD  = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]  VAL_ONES = '1;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

endpackage

/* rtl/spmr_in_if.sv */
// Command channel of the shuffled generator: valid/ready plus command and seed.
// Depends on spmr_pkg for the seed width.
`timescale 1ns / 1ps

interface spmr_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [spmr_pkg::VAL_W-1:0]   seed;

    modport source (output valid, output command, output seed, input ready);
    modport sink   (input valid, input command, input seed, output ready);
endinterface

/* rtl/spmr_out_if.sv */
// Result channel of the shuffled generator: valid/ready plus draw and fraction.
// Depends on spmr_pkg for the field widths.
`timescale 1ns / 1ps

interface spmr_out_if;
    logic                         valid;
    logic                         ready;
    logic [spmr_pkg::VAL_W-1:0]   draw;
    logic [spmr_pkg::FRAC_W-1:0]  fraction;

    modport source (output valid, output draw, output fraction, input ready);
    modport sink   (input valid, input draw, input fraction, output ready);
endinterface

/* rtl/shuffled_park_miller_rng.sv */
// Draw: after a command transfer the result turns valid as the block returns to idle, and
// only then is a new command taken. A result still held at the output stalls the last step.
// The slot select is one reciprocal multiply; the x16807 multiply, the mod 2^31-1 fold and
// the fraction are the S_MUL, S_FOLD and S_FRAC steps. Reseed (or first draw) first runs
// core steps to discard warm-up values and fill the table. Sync reset clears core value and
// last output; the table is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shuffled_park_miller_rng #(
    parameter int TABLE_DEPTH    = spmr_pkg::TABLE_DEPTH,
    parameter int WARMUP_DISCARD = spmr_pkg::WARMUP_DISCARD
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    spmr_in_if.sink            i_cmd,
    spmr_out_if.source         o_res
);

    localparam int VAL_W   = spmr_pkg::VAL_W;
    localparam int FRAC_W  = spmr_pkg::FRAC_W;
    localparam int PROD_W  = spmr_pkg::PROD_W;
    localparam int FRAC_SH = VAL_W - FRAC_W;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + WARMUP_DISCARD);
    localparam int QP_W    = 2 * VAL_W + 1;
    localparam logic [VAL_W:0] SLOT_DIV =
        (VAL_W+1)'(1 + (spmr_pkg::LCG_MOD - 1) / TABLE_DEPTH);
    localparam int SLOT_LOG = $clog2(SLOT_DIV);
    localparam int SLOT_SH  = VAL_W + SLOT_LOG;
    // ceil(2^SLOT_SH / SLOT_DIV): exact quotient for every 31-bit dividend
    localparam logic [VAL_W:0] RECIP = (VAL_W+1)'(((64'd1 << SLOT_SH) + 64'(SLOT_DIV)
                                                   - 64'd1) / 64'(SLOT_DIV));
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(TABLE_DEPTH + WARMUP_DISCARD - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_FOLD = 5'b01000,
        S_FRAC = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [VAL_W-1:0]       r_x, n_x;
    logic [VAL_W-1:0]       r_last, n_last;
    logic                   r_seeding, n_seeding;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_ovalid, n_ovalid;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic [IDX_W-1:0]       r_q, n_q;
    logic [VAL_W-1:0]       r_draw, n_draw;
    logic [FRAC_W-1:0]      r_frac, n_frac;
    logic [VAL_W-1:0]       r_rd;
    logic [VAL_W-1:0]       r_mem [TABLE_DEPTH];

    logic [VAL_W:0]         w_fsum;
    logic [VAL_W-1:0]       w_fold;
    logic [VAL_W-1:0]       w_seed;
    logic [QP_W-1:0]        w_qprod;
    logic [IDX_W-1:0]       w_slot;
    logic [VAL_W:0]         w_frem;
    logic [FRAC_W:0]        w_fq;
    logic [FRAC_W-1:0]      w_frac;
    logic                   w_tab_we;
    logic                   w_tab_re;
    logic [IDX_W-1:0]       w_tab_addr;

    // mod 2^31-1 fold of the 46-bit product: high part added back onto low part
    always_comb begin
        w_fsum = (VAL_W+1)'(r_prod[VAL_W-1:0]) + (VAL_W+1)'(r_prod[PROD_W-1:VAL_W]);
        if (w_fsum >= spmr_pkg::LCG_MOD) begin
            w_fsum = w_fsum - spmr_pkg::LCG_MOD;
        end
        w_fold = w_fsum[VAL_W-1:0];
    end

    // seed of zero or all ones runs from one
    always_comb begin
        w_seed = i_cmd.command ? i_cmd.seed : VAL_W'(1);
        if (w_seed == '0 || w_seed == spmr_pkg::VAL_ONES) begin
            w_seed = VAL_W'(1);
        end
    end

    // slot = last / SLOT_DIV as a constant reciprocal multiply
    assign w_qprod = QP_W'(r_last) * QP_W'(RECIP);
    assign w_slot  = ({1'b0, r_q} >= (IDX_W+1)'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) : r_q;

    // floor(d*2^24 / (2^31-1)): quotient estimate d>>7, remainder exceeds modulus at most once
    always_comb begin
        w_frem = {1'b0, r_rd[FRAC_SH-1:0], FRAC_W'(0)} + (VAL_W+1)'(r_rd[VAL_W-1:FRAC_SH]);
        w_fq   = (FRAC_W+1)'(r_rd[VAL_W-1:FRAC_SH])
               + (FRAC_W+1)'(w_frem >= spmr_pkg::LCG_MOD);
        w_frac = (w_fq > {1'b0, spmr_pkg::FRAC_MAX}) ? spmr_pkg::FRAC_MAX : w_fq[FRAC_W-1:0];
    end

    assign w_tab_addr = r_seeding ? r_cnt[IDX_W-1:0] : w_slot;
    assign w_tab_we   = (r_state == S_FOLD)
                      && (!r_seeding || ({1'b0, r_cnt} < (CNT_W+1)'(TABLE_DEPTH)));
    assign w_tab_re   = (r_state == S_FOLD) && !r_seeding;

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_last    = r_last;
        n_seeding = r_seeding;
        n_cnt     = r_cnt;
        n_ovalid  = r_ovalid;
        n_prod    = r_prod;
        n_q       = r_q;
        n_draw    = r_draw;
        n_frac    = r_frac;

        if (r_ovalid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    if (i_cmd.command || r_last == '0) begin
                        n_x       = w_seed;
                        n_seeding = 1'b1;
                        n_cnt     = CNT_INIT;
                        n_state   = S_MUL;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_q     = w_qprod[SLOT_SH +: IDX_W];
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_x) * PROD_W'(spmr_pkg::LCG_MULT);
                n_state = S_FOLD;
            end
            S_FOLD: begin
                n_x = w_fold;
                if (r_seeding) begin
                    if (r_cnt == '0) begin
                        // table[0] is the last core value: it becomes the last output
                        n_seeding = 1'b0;
                        n_last    = w_fold;
                        n_state   = S_DIV;
                    end else begin
                        n_cnt   = r_cnt - CNT_W'(1);
                        n_state = S_MUL;
                    end
                end else begin
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_draw   = r_rd;
                    n_frac   = w_frac;
                    n_last   = r_rd;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_x       <= '0;
            r_last    <= '0;
            r_seeding <= 1'b0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_x       <= n_x;
            r_last    <= n_last;
            r_seeding <= n_seeding;
            r_cnt     <= n_cnt;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_q    <= n_q;
        r_draw <= n_draw;
        r_frac <= n_frac;
    end

    // shuffle table: read returns the old entry when the same slot is refilled
    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_mem[w_tab_addr] <= w_fold;
        end
        if (w_tab_re) begin
            r_rd <= r_mem[w_tab_addr];
        end
    end

    assign i_cmd.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_ovalid;
    assign o_res.draw     = r_draw;
    assign o_res.fraction = r_frac;

    `SPMR_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, !i_cmd.ready)
    `SPMR_ASSERT(a_draw_range, i_clk, i_rst_n, o_res.valid, (o_res.draw != '0) && (o_res.draw != spmr_pkg::VAL_ONES))
    `SPMR_ASSERT(a_frac_cap, i_clk, i_rst_n, o_res.valid, o_res.fraction <= spmr_pkg::FRAC_MAX)
    `SPMR_ASSERT(a_last_tracks_draw, i_clk, i_rst_n, $rose(o_res.valid), r_last == o_res.draw)

endmodule

/* test/tb.sv */
// Self-checking testbench for the shuffled minimal-standard generator.
// Uses spmr_pkg, spmr_in_if and spmr_out_if; drives the top level with random stalls.
`timescale 1ns / 1ps

module tb;

    localparam int VAL_W          = spmr_pkg::VAL_W;
    localparam int FRAC_W         = spmr_pkg::FRAC_W;
    localparam int TABLE_DEPTH    = spmr_pkg::TABLE_DEPTH;
    localparam int WARMUP_DISCARD = spmr_pkg::WARMUP_DISCARD;
    localparam logic [VAL_W:0]    LCG_MOD  = spmr_pkg::LCG_MOD;
    localparam logic [VAL_W-1:0]  VAL_ONES = spmr_pkg::VAL_ONES;
    localparam logic [FRAC_W-1:0] FRAC_MAX = spmr_pkg::FRAC_MAX;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    localparam int unsigned SLOT_DIV   = 1 + (int'(LCG_MOD) - 1) / TABLE_DEPTH;
    localparam logic [VAL_W-1:0] SEED_ONE = 31'd1;
    localparam int SETTLE_CYCLES = 120;     // covers a reseed plus one draw

    typedef struct packed {
        logic [VAL_W-1:0]  draw;
        logic [FRAC_W-1:0] fraction;
    } t_draw_result;

    logic i_clk;
    logic i_rst_n;

    spmr_in_if  cmd_if ();
    spmr_out_if res_if ();

    shuffled_park_miller_rng u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // generator mirror
    logic [VAL_W-1:0] core_val;
    logic [VAL_W-1:0] prev_out;
    logic [VAL_W-1:0] shuffle_slots [TABLE_DEPTH];

    t_draw_result pending_draws[$];

    int  fail_count      = 0;
    int  results_checked = 0;
    int  draws_sent      = 0;
    int  reseeds_sent    = 0;
    bit  src_idle_on     = 1'b1;
    bit  sink_idle_on    = 1'b1;
    int  sink_hold_len   = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n        <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= CMD_DRAW;
        cmd_if.seed    <= '0;
        res_if.ready   <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #4_000_000;
        $display("timeout at %0t, %0d results still pending", $time, pending_draws.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [VAL_W-1:0] lcg_advance(input logic [VAL_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(spmr_pkg::LCG_MULT);
        return VAL_W'(prod % 64'(LCG_MOD));
    endfunction

    function automatic void reseed_slots(input logic [VAL_W-1:0] seed);
        logic [VAL_W-1:0] x;
        x = seed;
        // zero and the modulus itself would lock the core at zero
        if (x == '0 || {1'b0, x} == LCG_MOD)
            x = SEED_ONE;
        for (int j = TABLE_DEPTH + WARMUP_DISCARD - 1; j >= 0; j--) begin
            x = lcg_advance(x);
            if (j < TABLE_DEPTH)
                shuffle_slots[j] = x;
        end
        core_val = x;
        prev_out = shuffle_slots[0];
    endfunction

    function automatic t_draw_result predict_draw(input logic cmd,
                                                  input logic [VAL_W-1:0] seed);
        int unsigned      slot;
        logic [VAL_W-1:0] drawn;
        logic [63:0]      scaled;
        t_draw_result     r;
        if (cmd == CMD_RESEED)
            reseed_slots(seed);
        else if (prev_out == '0)
            reseed_slots(SEED_ONE);
        core_val = lcg_advance(core_val);
        slot = int'(prev_out) / SLOT_DIV;
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        drawn = shuffle_slots[slot];
        shuffle_slots[slot] = core_val;
        prev_out = drawn;
        scaled = (64'(drawn) << FRAC_W) / 64'(LCG_MOD);
        if (scaled > 64'(FRAC_MAX))
            scaled = 64'(FRAC_MAX);
        r.draw     = drawn;
        r.fraction = FRAC_W'(scaled);
        return r;
    endfunction

    // one command transfer; optional idle burst in front of it
    task automatic send_cmd(input logic cmd, input logic [VAL_W-1:0] seed);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.seed    <= seed;
        do
            @(posedge i_clk);
        while (!(cmd_if.valid && cmd_if.ready));
        pending_draws.push_back(predict_draw(cmd, seed));
        if (cmd == CMD_RESEED)
            reseeds_sent++;
        else
            draws_sent++;
    endtask

    // result side: random stalls, or one long hold when requested
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (sink_hold_len > 0) begin
                n = sink_hold_len;
                sink_hold_len = 0;
                res_if.ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 10);
                res_if.ready <= 1'b0;
            end else begin
                n = 1;
                res_if.ready <= 1'b1;
            end
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_draw_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_draws.size() == 0) begin
                $display("%0t: unexpected result draw=%0d fraction=%0d",
                         $time, res_if.draw, res_if.fraction);
                fail_count++;
            end else begin
                want = pending_draws.pop_front();
                results_checked++;
                if (res_if.draw !== want.draw) begin
                    $display("%0t: draw mismatch: expected %0d, got %0d",
                             $time, want.draw, res_if.draw);
                    fail_count++;
                end
                if (res_if.fraction !== want.fraction) begin
                    $display("%0t: fraction mismatch: expected %0d, got %0d",
                             $time, want.fraction, res_if.fraction);
                    fail_count++;
                end
            end
        end
    end

    // first draw after reset must self-seed from one, ignoring the seed field
    task automatic test_unseeded_draw();
        send_cmd(CMD_DRAW, 31'h5A5A_5A5A);
        send_cmd(CMD_DRAW, '0);
        send_cmd(CMD_DRAW, VAL_ONES);
    endtask

    task automatic test_seed_extremes();
        logic [VAL_W-1:0] seeds [7];
        seeds = '{31'd0, 31'd1, 31'd2147483646, VAL_ONES, 31'h2AAA_AAAA,
                  31'h5555_5555, 31'd16807};
        foreach (seeds[i]) begin
            send_cmd(CMD_RESEED, seeds[i]);
            send_cmd(CMD_DRAW, ~seeds[i]);
        end
    endtask

    // sink holds off while commands keep coming, so the block backs up
    task automatic test_backpressure();
        sink_hold_len = 200;
        for (int i = 0; i < 8; i++)
            send_cmd((i == 3) ? CMD_RESEED : CMD_DRAW, VAL_W'($urandom));
    endtask

    task automatic test_random(input int count);
        logic [VAL_W-1:0] seed;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 15))
                0:       seed = '0;
                1:       seed = VAL_ONES;
                default: seed = VAL_W'($urandom);
            endcase
            // mostly long draw runs, occasional reseeds
            if ($urandom_range(0, 19) == 0)
                send_cmd(CMD_RESEED, seed);
            else
                send_cmd(CMD_DRAW, seed);
        end
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        test_unseeded_draw();
        test_seed_extremes();
        test_backpressure();
        test_random(600);

        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random(200);

        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_random(500);

        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random(200);

        cmd_if.valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d draws and %0d reseeds, %0d results compared",
                 draws_sent, reseeds_sent, results_checked);
        $display("includes unseeded draw, zero/modulus seeds and a 200-cycle output stall");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/spmr_pkg.sv
rtl/spmr_in_if.sv
rtl/spmr_out_if.sv
rtl/shuffled_park_miller_rng.sv
test/tb.sv
